// ----- design/dsvrt_pkg.sv -----
// ----------------------------------------------------------------------------
// dsvrt_pkg: shared types and constants of the row tokenizer
// Result kinds, quote tracking codes and the step interface structs.
// ----------------------------------------------------------------------------
package dsvrt_pkg;

  localparam logic [7:0] NL_CHAR        = 8'h0A;
  localparam logic [7:0] QUOTE_CHAR     = 8'h22;
  localparam logic [7:0] DELIM_RESET    = 8'd44;

  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW       = FIFO_AW + 1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    QM_OUTSIDE = 2'd0,
    QM_INSIDE  = 2'd1,
    QM_HELD    = 2'd2
  } qmode_t;

  typedef struct packed {
    qmode_t qm;
    logic   fne;
  } tok_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       ffp;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
    tok_state_t state;
  } step_out_t;

endpackage

// ----- design/dsvrt_if.sv -----
// ----------------------------------------------------------------------------
// dsvrt_if: valid/ready channels of the row tokenizer
// Input word channel, result word channel and delimiter write channel.
// ----------------------------------------------------------------------------
interface dsvrt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface dsvrt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] out_byte;
  logic       final_field_present;
  logic       last_of_run;

  modport source (output valid, output result_kind, output out_byte,
                  output final_field_present, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input out_byte,
                  input final_field_present, input last_of_run, output ready);
endinterface

interface dsvrt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] delimiter_char;

  modport source (output valid, output delimiter_char, input ready);
  modport sink   (input valid, input delimiter_char, output ready);
endinterface

// ----- design/dsv_row_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// dsv_row_tokenizer_top: delimiter-separated text tokenizer
// Splits a byte stream into data bytes, field ends and row ends.
// ----------------------------------------------------------------------------
// The block takes one text byte per word on in_ch and can accept a new word
// in every cycle while the queue has room. Each byte is classified against
// the quote state and the delimiter register; its zero, one or two result
// words go into a four-word result queue that drives out_ch. Input is taken
// whenever at least two queue slots are free, so with an attentive consumer
// the sustained rate is one byte per cycle, limited only by the one result
// word per cycle that out_ch delivers (bytes that raise a field end and a
// row end together need two output words). Results are registered in the
// queue before they appear on out_ch. The delimiter is written through cfg_ch,
// which is always ready; it should change only while no results are pending.
// ----------------------------------------------------------------------------
module dsv_row_tokenizer_top (
  input  logic        clk,
  input  logic        rst_n,
  dsvrt_in_if.sink    in_ch,
  dsvrt_out_if.source out_ch,
  dsvrt_cfg_if.sink   cfg_ch
);
  import dsvrt_pkg::*;

  logic [7:0]         delim_r;
  tok_state_t         state_r;
  step_out_t          step;

  result_t            fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r;
  logic [FIFO_CW-1:0] cnt_nxt;

  logic               in_acc;
  logic               out_acc;
  logic [1:0]         push_n;

  // Configuration: the delimiter register accepts a write in any cycle.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RESET;
    end else if (cfg_ch.valid) begin
      delim_r <= cfg_ch.delimiter_char;
    end
  end

  // Classification of the incoming byte.
  dsvrt_step u_step (
    .in_byte    (in_ch.in_byte),
    .stream_end (in_ch.stream_end),
    .delim      (delim_r),
    .cur        (state_r),
    .step       (step)
  );

  // Two free slots guarantee room for the worst case of one byte.
  assign in_ch.ready = (cnt_r <= FIFO_CW'(FIFO_DEPTH - 2));
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign out_acc     = out_ch.valid & out_ch.ready;
  assign push_n      = in_acc ? step.count : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{qm: QM_OUTSIDE, fne: 1'b0};
    end else if (in_acc) begin
      state_r <= step.state;
    end
  end

  // Result queue. Entries need no reset: the count qualifies them.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem_r[wr_ptr_r] <= step.res0;
    end
    if (push_n == 2'd2) begin
      fifo_mem_r[wr_ptr_r + FIFO_AW'(1)] <= step.res1;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r + FIFO_CW'(push_n) - FIFO_CW'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push_n);
      rd_ptr_r <= rd_ptr_r + FIFO_AW'(out_acc);
      cnt_r    <= cnt_nxt;
    end
  end

  assign out_ch.valid               = (cnt_r != '0);
  assign out_ch.result_kind         = fifo_mem_r[rd_ptr_r].kind;
  assign out_ch.out_byte            = fifo_mem_r[rd_ptr_r].data;
  assign out_ch.final_field_present = fifo_mem_r[rd_ptr_r].ffp;
  assign out_ch.last_of_run         = fifo_mem_r[rd_ptr_r].last;

  // The queue never holds more words than it has slots.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  // A byte that ends the stream leaves the tokenizer at a row start.
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.stream_end |=> state_r.qm == QM_OUTSIDE && !state_r.fne)
    else $error("stream end did not close the row");

  // A newline outside quotes clears the field state.
  a_nl_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && state_r.qm == QM_OUTSIDE && in_ch.in_byte == NL_CHAR
    |=> !state_r.fne && state_r.qm == QM_OUTSIDE)
    else $error("newline did not end the row");

  // An accepted byte that yields results makes the queue non-empty next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |=> out_ch.valid)
    else $error("pushed result not visible");

endmodule

// ----- design/dsvrt_step.sv -----
// ----------------------------------------------------------------------------
// dsvrt_step: per-byte classifier
// Computes the next quote state and up to two result words for one byte.
// ----------------------------------------------------------------------------
module dsvrt_step (
  input  logic [7:0]             in_byte,
  input  logic                   stream_end,
  input  logic [7:0]             delim,
  input  dsvrt_pkg::tok_state_t  cur,
  output dsvrt_pkg::step_out_t   step
);
  import dsvrt_pkg::*;

  logic    outside;
  logic    row_done;
  logic    first_v;
  logic    row_v;
  result_t first_res;
  result_t row_res;
  tok_state_t nxt;

  always_comb begin
    nxt       = cur;
    outside   = 1'b0;
    row_done  = 1'b0;
    first_v   = 1'b0;
    first_res = '{kind: KIND_DATA, data: in_byte, ffp: 1'b0, last: 1'b0};

    unique case (cur.qm)
      QM_INSIDE: begin
        if (in_byte == QUOTE_CHAR) begin
          nxt.qm = QM_HELD;
        end else begin
          first_v = 1'b1;
          nxt.fne = 1'b1;
        end
      end
      QM_HELD: begin
        if (in_byte == QUOTE_CHAR) begin
          first_v = 1'b1;
          nxt.fne = 1'b1;
          nxt.qm  = QM_INSIDE;
        end else begin
          nxt.qm  = QM_OUTSIDE;
          outside = 1'b1;
        end
      end
      default: begin
        // The unused code is handled as outside quotes.
        nxt.qm  = QM_OUTSIDE;
        outside = 1'b1;
      end
    endcase

    if (outside) begin
      priority if (in_byte == NL_CHAR) begin
        row_done = 1'b1;
      end else if (in_byte == delim) begin
        first_v        = 1'b1;
        first_res.kind = KIND_FIELD;
        first_res.data = 8'd0;
        nxt.fne        = 1'b0;
      end else if (in_byte == QUOTE_CHAR) begin
        nxt.qm = QM_INSIDE;
      end else begin
        first_v = 1'b1;
        nxt.fne = 1'b1;
      end
    end

    row_v   = row_done | stream_end;
    row_res = '{kind: KIND_ROW, data: 8'd0, ffp: nxt.fne, last: 1'b1};
    if (row_v) begin
      nxt.fne = 1'b0;
      nxt.qm  = QM_OUTSIDE;
    end

    step.state = nxt;
    step.count = {1'b0, first_v} + {1'b0, row_v};
    if (first_v) begin
      step.res0      = first_res;
      step.res0.last = ~row_v;
      step.res1      = row_res;
    end else begin
      step.res0 = row_res;
      step.res1 = row_res;
    end
  end

endmodule
